// ===== hw/rtl/bpsd_pkg.sv =====
// Shared types and constants of the BMP pixel stream decoder.
`default_nettype none
package bpsd_pkg;

    localparam int MAX_DIM_DEF     = 8192;
    localparam int PAL_ENTRIES_DEF = 256;

    // request types
    localparam logic [1:0] REQ_PAL   = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_DATA  = 2'd2;

    // result kinds
    localparam logic [1:0] RES_RUN  = 2'd0;
    localparam logic [1:0] RES_DONE = 2'd1;
    localparam logic [1:0] RES_ERR  = 2'd2;

    // compression codes
    localparam logic [1:0] COMP_RGB  = 2'd0;
    localparam logic [1:0] COMP_RLE8 = 2'd1;
    localparam logic [1:0] COMP_RLE4 = 2'd2;
    localparam logic [1:0] COMP_BF   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_BPP   = 3'd0;
    localparam logic [2:0] CFG_COMP  = 3'd1;
    localparam logic [2:0] CFG_W     = 3'd2;
    localparam logic [2:0] CFG_H     = 3'd3;
    localparam logic [2:0] CFG_UP    = 3'd4;
    localparam logic [2:0] CFG_RMASK = 3'd5;
    localparam logic [2:0] CFG_GMASK = 3'd6;
    localparam logic [2:0] CFG_BMASK = 3'd7;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic [7:0] palette_index;
        logic [7:0] palette_red;
        logic [7:0] palette_green;
        logic [7:0] palette_blue;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [12:0] pixel_x;
        logic [12:0] pixel_row;
        logic [7:0]  run_length;
        logic [7:0]  first_red;
        logic [7:0]  first_green;
        logic [7:0]  first_blue;
        logic [7:0]  second_red;
        logic [7:0]  second_green;
        logic [7:0]  second_blue;
        logic        last_of_item;
    } t_out_res;

    typedef struct packed {
        logic        en;
        logic [7:0]  idx;
        logic [23:0] rgb;
    } t_pal_wr;

    typedef struct packed {
        logic       en;
        logic [7:0] idx_a;
        logic [7:0] idx_b;
    } t_pal_rd;

endpackage
`default_nettype wire

// ===== hw/rtl/bpsd_palette.sv =====
// Palette memory: one write port, two registered read ports, cleared by valid bits.
`default_nettype none
module bpsd_palette #(
    parameter int PALETTE_ENTRIES = bpsd_pkg::PAL_ENTRIES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bpsd_pkg::t_pal_wr i_wr,
    input  wire bpsd_pkg::t_pal_rd i_rd,
    output logic [23:0]           o_rd_a,
    output logic [23:0]           o_rd_b
);

    localparam int PAW = $clog2(PALETTE_ENTRIES);

    logic [23:0]                r_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_vld;
    logic [23:0]                r_da, r_db;
    logic                       r_oka, r_okb;
    logic                       wr_in, rda_in, rdb_in;

    assign wr_in  = {1'b0, i_wr.idx} < 9'(PALETTE_ENTRIES);
    assign rda_in = {1'b0, i_rd.idx_a} < 9'(PALETTE_ENTRIES);
    assign rdb_in = {1'b0, i_rd.idx_b} < 9'(PALETTE_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (i_wr.en && wr_in) begin
            r_mem[i_wr.idx[PAW-1:0]] <= i_wr.rgb;
        end
        if (i_rd.en) begin
            r_da <= r_mem[i_rd.idx_a[PAW-1:0]];
            r_db <= r_mem[i_rd.idx_b[PAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_oka <= 1'b0;
            r_okb <= 1'b0;
        end else begin
            if (i_wr.en && wr_in) begin
                r_vld[i_wr.idx[PAW-1:0]] <= 1'b1;
            end
            if (i_rd.en) begin
                r_oka <= rda_in && r_vld[i_rd.idx_a[PAW-1:0]];
                r_okb <= rdb_in && r_vld[i_rd.idx_b[PAW-1:0]];
            end
        end
    end

    // never-written or out-of-range entries read as black
    assign o_rd_a = r_oka ? r_da : 24'd0;
    assign o_rd_b = r_okb ? r_db : 24'd0;

endmodule
`default_nettype wire

// ===== hw/rtl/bmp_pixel_stream_decoder_unit.sv =====
// BMP pixel stream decoder top level: request sequencer, pixel unpacking and run output.
// Input channel (i_in_*): one request per handshake: a palette write, a start image, or
//   one byte of pixel data. Output channel (o_out_*): pixel runs, image finished and
//   configuration error results; last_of_item marks the last result of a request.
// Configuration port: plain write (i_cfg_we, i_cfg_index, i_cfg_data), written by the user
//   while idle, which the block itself does not enforce; values take effect at the next start image.
// Steps: a palette write, a start image without bitfields, or a byte with no active image
//   is handled in the idle state; a start image with an error result passes the error
//   state, and with bitfields the mask scan, which scans each mask one bit per cycle.
//   A pixel data byte of an active image steps through accept, decode, one scan step
//   for each of the four run slots and done, plus one emit step per result (palette read
//   in the scan step, output load in the emit step) and a finish step for an image finished
//   result; 1 bpp bytes give up to four runs. Results leave through a single output
//   register, so the next request is taken while the last result still waits.
// Reset clears the palette (valid bits), the position state and the output register;
//   no image is active. A stalled receiver holds the sequencer before its next result.
`default_nettype none
module bmp_pixel_stream_decoder_unit #(
    parameter int MAX_DIMENSION   = bpsd_pkg::MAX_DIM_DEF,
    parameter int PALETTE_ENTRIES = bpsd_pkg::PAL_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire bpsd_pkg::t_in_req  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output bpsd_pkg::t_out_res      o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    localparam int CW = $clog2(MAX_DIMENSION + 1);
    localparam int XW = 20;
    localparam int RW = 15;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MASK = 7'b0000010,
        ST_ERRO = 7'b0000100,
        ST_CALC = 7'b0001000,
        ST_SCAN = 7'b0010000,
        ST_EMIT = 7'b0100000,
        ST_FIN  = 7'b1000000
    } t_state;

    typedef enum logic [4:0] {
        PH_COUNT  = 5'b00001,
        PH_SECOND = 5'b00010,
        PH_DX     = 5'b00100,
        PH_DY     = 5'b01000,
        PH_ABS    = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [7:0]    n;
        logic [7:0]    ia;
        logic [7:0]    ib;
        logic          direct;
        logic [23:0]   color;
    } t_raw;

    typedef struct packed {
        logic        vld;
        logic [12:0] x;
        logic [7:0]  len;
        logic [7:0]  ia;
        logic [7:0]  ib;
        logic        direct;
        logic [23:0] color;
    } t_cand;

    // configuration
    logic [5:0]  r_cfg_bpp;
    logic [1:0]  r_cfg_comp;
    logic [13:0] r_cfg_w, r_cfg_h;
    logic        r_cfg_up;
    logic [31:0] r_cfg_mask [3];

    // latched image
    logic [5:0]  r_bpp;
    logic [1:0]  r_comp;
    logic [13:0] r_w, r_h;
    logic        r_up;
    logic [15:0] r_line_len;
    logic        r_active;

    // decode state
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [15:0]   r_bir;
    logic [1:0]    r_pos;
    logic [15:0]   r_pix;
    logic [31:0]   r_asm;
    t_phase        r_phase;
    logic [7:0]    r_cnt;
    logic [8:0]    r_absl;
    logic [4:0]    r_rs [3];
    logic [3:0]    r_ls [3];

    t_state      r_st;
    logic [7:0]  r_byte;
    t_cand       r_cand [4];
    logic        r_fin;
    logic [12:0] r_orow;
    logic [2:0]  r_j;

    logic [31:0] r_mt;
    logic [1:0]  r_mch;
    logic        r_mph;
    logic [4:0]  r_mrs;
    logic [5:0]  r_mcnt;

    logic               r_out_valid;
    bpsd_pkg::t_out_res r_out;
    bpsd_pkg::t_out_res n_out;
    logic               out_load;

    // next values from the byte decode
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [15:0]   n_bir;
    logic [1:0]    n_pos;
    logic [15:0]   n_pix;
    logic [31:0]   n_asm;
    t_phase        n_phase;
    logic [7:0]    n_cnt;
    logic [8:0]    n_absl;
    logic          n_fin;
    t_raw          raw [4];
    t_cand         cand [4];

    bpsd_pkg::t_pal_wr pal_wr;
    bpsd_pkg::t_pal_rd pal_rd;
    logic [23:0]       rd_a, rd_b;

    logic        in_acc, out_free, cfg_ok;
    logic [19:0] prod;
    logic [20:0] ll_sum;
    logic [3:0]  cv_mask;
    logic        later;
    logic [4:0]  m_rs_f;
    logic [3:0]  m_ls_f;

    assign o_in_ready  = (r_st == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign pal_wr.en  = in_acc && (i_in_data.req_type == bpsd_pkg::REQ_PAL);
    assign pal_wr.idx = i_in_data.palette_index;
    assign pal_wr.rgb = {i_in_data.palette_red, i_in_data.palette_green,
                         i_in_data.palette_blue};
    assign pal_rd.en    = (r_st == ST_SCAN) && !r_j[2] && r_cand[r_j[1:0]].vld;
    assign pal_rd.idx_a = r_cand[r_j[1:0]].ia;
    assign pal_rd.idx_b = r_cand[r_j[1:0]].ib;

    bpsd_palette #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_palette (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (pal_wr),
        .i_rd   (pal_rd),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [7:0] n);
        logic [CW:0] s;
        s = {1'b0, a} + (CW+1)'(n);
        return (s > (CW+1)'(MAX_DIMENSION)) ? CW'(MAX_DIMENSION) : s[CW-1:0];
    endfunction

    // start image checks
    always_comb begin
        cfg_ok = 1'b1;
        case (r_cfg_bpp)
            6'd1, 6'd4, 6'd8, 6'd16, 6'd24, 6'd32: cfg_ok = 1'b1;
            default: cfg_ok = 1'b0;
        endcase
        if (r_cfg_comp == bpsd_pkg::COMP_RLE8 && r_cfg_bpp != 6'd8) cfg_ok = 1'b0;
        if (r_cfg_comp == bpsd_pkg::COMP_RLE4 && r_cfg_bpp != 6'd4) cfg_ok = 1'b0;
        if (r_cfg_comp == bpsd_pkg::COMP_BF && r_cfg_bpp != 6'd16 && r_cfg_bpp != 6'd32)
            cfg_ok = 1'b0;
        if (r_cfg_w == 14'd0 || 32'(r_cfg_w) > MAX_DIMENSION) cfg_ok = 1'b0;
        if (r_cfg_h == 14'd0 || 32'(r_cfg_h) > MAX_DIMENSION) cfg_ok = 1'b0;
        prod   = 20'(r_cfg_w * r_cfg_bpp);
        ll_sum = 21'(prod) + 21'd31;
    end

    // shifts from a finished mask scan; only the top eight bits of a wide mask count
    always_comb begin
        m_rs_f = (r_mcnt > 6'd8) ? 5'(r_mrs + 5'(r_mcnt - 6'd8)) : r_mrs;
        m_ls_f = (r_mcnt > 6'd8) ? 4'd0 : 4'(6'd8 - r_mcnt);
    end

    // byte decode
    always_comb begin
        logic        r8, two;
        logic [7:0]  b, hi, lo, nn;
        logic [8:0]  absl_d;
        logic [16:0] bir1;
        logic [1:0]  lastpos;
        logic [31:0] sh;
        logic [19:0] rem;
        n_col   = r_col;
        n_row   = r_row;
        n_bir   = r_bir;
        n_pos   = r_pos;
        n_pix   = r_pix;
        n_asm   = r_asm;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_absl  = r_absl;
        n_fin   = 1'b0;
        for (int i = 0; i < 4; i++) raw[i] = '0;
        b       = r_byte;
        hi      = {4'd0, b[7:4]};
        lo      = {4'd0, b[3:0]};
        r8      = (r_comp == bpsd_pkg::COMP_RLE8);
        two     = 1'b0;
        nn      = 8'd1;
        absl_d  = 9'd0;
        bir1    = 17'(r_bir) + 17'd1;
        lastpos = (r_bpp == 6'd16) ? 2'd1 : ((r_bpp == 6'd24) ? 2'd2 : 2'd3);
        sh      = '0;
        rem     = '0;
        if (r_comp == bpsd_pkg::COMP_RLE8 || r_comp == bpsd_pkg::COMP_RLE4) begin
            case (r_phase)
                PH_COUNT: begin
                    n_cnt   = b;
                    n_phase = PH_SECOND;
                end
                PH_SECOND: begin
                    n_phase = PH_COUNT;
                    if (r_cnt != 8'd0) begin
                        raw[0].x  = XW'(r_col);
                        raw[0].n  = r_cnt;
                        raw[0].ia = r8 ? b : hi;
                        raw[0].ib = r8 ? b : ((r_cnt == 8'd1) ? hi : lo);
                        n_col     = sat_add(r_col, r_cnt);
                    end else if (b == 8'd0) begin
                        n_col = '0;
                        n_row = r_row + RW'(1);
                        n_fin = (r_row + RW'(1)) >= RW'(r_h);
                    end else if (b == 8'd1) begin
                        n_fin = 1'b1;
                    end else if (b == 8'd2) begin
                        n_phase = PH_DX;
                    end else begin
                        n_cnt   = b;
                        n_absl  = r8 ? (((9'(b) + 9'd1) >> 1) << 1)
                                     : (((9'(b) + 9'd3) >> 2) << 1);
                        n_phase = PH_ABS;
                    end
                end
                PH_DX: begin
                    n_col   = sat_add(r_col, b);
                    n_phase = PH_DY;
                end
                PH_DY: begin
                    n_row   = r_row + RW'(b);
                    n_phase = PH_COUNT;
                    n_fin   = (r_row + RW'(b)) >= RW'(r_h);
                end
                PH_ABS: begin
                    absl_d = (r_absl != 9'd0) ? r_absl - 9'd1 : 9'd0;
                    n_absl = absl_d;
                    if (r_cnt != 8'd0) begin
                        two       = !r8 && (r_cnt >= 8'd2);
                        nn        = two ? 8'd2 : 8'd1;
                        raw[0].x  = XW'(r_col);
                        raw[0].n  = nn;
                        raw[0].ia = r8 ? b : hi;
                        raw[0].ib = two ? lo : (r8 ? b : hi);
                        n_col     = sat_add(r_col, nn);
                        n_cnt     = r_cnt - nn;
                    end
                    if (absl_d == 9'd0) n_phase = PH_COUNT;
                end
                default: n_phase = PH_COUNT;
            endcase
        end else begin
            case (r_bpp)
                6'd1: begin
                    for (int j = 0; j < 4; j++) begin
                        raw[j].x  = XW'({r_bir, 3'b000}) + XW'(2 * j);
                        raw[j].n  = 8'd2;
                        raw[j].ia = {7'd0, b[7-2*j]};
                        raw[j].ib = {7'd0, b[6-2*j]};
                    end
                end
                6'd4: begin
                    raw[0].x  = XW'({r_bir, 1'b0});
                    raw[0].n  = 8'd2;
                    raw[0].ia = hi;
                    raw[0].ib = lo;
                end
                6'd8: begin
                    raw[0].x  = XW'(r_bir);
                    raw[0].n  = 8'd1;
                    raw[0].ia = b;
                    raw[0].ib = b;
                end
                default: begin
                    n_asm = (r_pos == 2'd0) ? 32'(b) : (r_asm | (32'(b) << {r_pos, 3'b000}));
                    if (r_pos == lastpos) begin
                        raw[0].x      = XW'(r_pix);
                        raw[0].n      = 8'd1;
                        raw[0].direct = 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            sh = n_asm >> r_rs[k];
                            raw[0].color[23-8*k -: 8] = r_ls[k][3] ? 8'd0
                                                       : 8'(sh[7:0] << r_ls[k]);
                        end
                        n_pos = 2'd0;
                        n_pix = r_pix + 16'd1;
                    end else begin
                        n_pos = r_pos + 2'd1;
                    end
                end
            endcase
            if (bir1 >= 17'(r_line_len)) begin
                n_bir = '0;
                n_pos = 2'd0;
                n_pix = '0;
                n_row = r_row + RW'(1);
                n_fin = (r_row + RW'(1)) >= RW'(r_h);
            end else begin
                n_bir = bir1[15:0];
            end
        end
        // clip at the right edge
        for (int i = 0; i < 4; i++) begin
            rem            = XW'(r_w) - raw[i].x;
            cand[i].vld    = (raw[i].x < XW'(r_w)) && (raw[i].n != 8'd0);
            cand[i].x      = raw[i].x[12:0];
            cand[i].len    = (rem < XW'(raw[i].n)) ? rem[7:0] : raw[i].n;
            cand[i].ia     = raw[i].ia;
            cand[i].ib     = raw[i].ib;
            cand[i].direct = raw[i].direct;
            cand[i].color  = raw[i].color;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) cv_mask[i] = r_cand[i].vld;
        later = |(cv_mask >> (r_j + 3'd1));
    end

    // result word loaded into the output register
    always_comb begin
        n_out    = '0;
        out_load = 1'b0;
        case (r_st)
            ST_ERRO: begin
                n_out.result_kind  = bpsd_pkg::RES_ERR;
                n_out.last_of_item = 1'b1;
                out_load           = out_free;
            end
            ST_FIN: begin
                n_out.result_kind  = bpsd_pkg::RES_DONE;
                n_out.last_of_item = 1'b1;
                out_load           = out_free;
            end
            ST_EMIT: begin
                n_out.result_kind  = bpsd_pkg::RES_RUN;
                n_out.pixel_x      = r_cand[r_j[1:0]].x;
                n_out.pixel_row    = r_orow;
                n_out.run_length   = r_cand[r_j[1:0]].len;
                {n_out.first_red, n_out.first_green, n_out.first_blue} =
                    r_cand[r_j[1:0]].direct ? r_cand[r_j[1:0]].color : rd_a;
                {n_out.second_red, n_out.second_green, n_out.second_blue} =
                    r_cand[r_j[1:0]].direct ? r_cand[r_j[1:0]].color : rd_b;
                n_out.last_of_item = !later && !r_fin;
                out_load           = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bpp     <= 6'd24;
            r_cfg_comp    <= bpsd_pkg::COMP_RGB;
            r_cfg_w       <= 14'd1;
            r_cfg_h       <= 14'd1;
            r_cfg_up      <= 1'b1;
            r_cfg_mask[0] <= '0;
            r_cfg_mask[1] <= '0;
            r_cfg_mask[2] <= '0;
            r_bpp         <= 6'd24;
            r_comp        <= bpsd_pkg::COMP_RGB;
            r_w           <= 14'd1;
            r_h           <= 14'd1;
            r_up          <= 1'b1;
            r_line_len    <= 16'd4;
            r_active      <= 1'b0;
            r_col         <= '0;
            r_row         <= '0;
            r_bir         <= '0;
            r_pos         <= '0;
            r_pix         <= '0;
            r_asm         <= '0;
            r_phase       <= PH_COUNT;
            r_cnt         <= '0;
            r_absl        <= '0;
            for (int k = 0; k < 3; k++) begin
                r_rs[k] <= '0;
                r_ls[k] <= '0;
            end
            r_st          <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_out         <= '0;
            r_j           <= '0;
            r_fin         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bpsd_pkg::CFG_BPP:   r_cfg_bpp     <= i_cfg_data[5:0];
                    bpsd_pkg::CFG_COMP:  r_cfg_comp    <= i_cfg_data[1:0];
                    bpsd_pkg::CFG_W:     r_cfg_w       <= i_cfg_data[13:0];
                    bpsd_pkg::CFG_H:     r_cfg_h       <= i_cfg_data[13:0];
                    bpsd_pkg::CFG_UP:    r_cfg_up      <= i_cfg_data[0];
                    bpsd_pkg::CFG_RMASK: r_cfg_mask[0] <= i_cfg_data;
                    bpsd_pkg::CFG_GMASK: r_cfg_mask[1] <= i_cfg_data;
                    bpsd_pkg::CFG_BMASK: r_cfg_mask[2] <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_st)
                ST_IDLE: begin
                    if (in_acc && i_in_data.req_type == bpsd_pkg::REQ_START) begin
                        r_bpp      <= r_cfg_bpp;
                        r_comp     <= r_cfg_comp;
                        r_w        <= r_cfg_w;
                        r_h        <= r_cfg_h;
                        r_up       <= r_cfg_up;
                        r_line_len <= {ll_sum[18:5], 2'b00};
                        r_col      <= '0;
                        r_row      <= '0;
                        r_bir      <= '0;
                        r_pos      <= '0;
                        r_pix      <= '0;
                        r_asm      <= '0;
                        r_phase    <= PH_COUNT;
                        r_cnt      <= '0;
                        r_absl     <= '0;
                        r_mt       <= r_cfg_mask[0];
                        r_mch      <= 2'd0;
                        r_mph      <= 1'b0;
                        r_mrs      <= '0;
                        r_mcnt     <= '0;
                        if (!cfg_ok) begin
                            r_active <= 1'b0;
                            r_st     <= ST_ERRO;
                        end else if (r_cfg_comp == bpsd_pkg::COMP_BF) begin
                            r_active <= 1'b0;
                            r_st     <= ST_MASK;
                        end else if (r_cfg_bpp == 6'd16) begin
                            r_rs[0] <= 5'd10; r_ls[0] <= 4'd3;
                            r_rs[1] <= 5'd5;  r_ls[1] <= 4'd3;
                            r_rs[2] <= 5'd0;  r_ls[2] <= 4'd3;
                            r_active <= 1'b1;
                        end else begin
                            r_rs[0] <= 5'd16; r_ls[0] <= 4'd0;
                            r_rs[1] <= 5'd8;  r_ls[1] <= 4'd0;
                            r_rs[2] <= 5'd0;  r_ls[2] <= 4'd0;
                            r_active <= 1'b1;
                        end
                    end else if (in_acc && i_in_data.req_type == bpsd_pkg::REQ_DATA &&
                                 r_active) begin
                        r_byte <= i_in_data.data_byte;
                        r_st   <= ST_CALC;
                    end
                end
                ST_MASK: begin
                    if (!r_mph && r_mt == 32'd0) begin
                        // zero mask: channel reads as zero
                        r_rs[r_mch] <= 5'd0;
                        r_ls[r_mch] <= 4'd8;
                        if (r_mch == 2'd2) begin
                            r_active <= 1'b1;
                            r_st     <= ST_IDLE;
                        end else begin
                            r_mch  <= r_mch + 2'd1;
                            r_mt   <= r_cfg_mask[r_mch + 2'd1];
                            r_mrs  <= '0;
                            r_mcnt <= '0;
                        end
                    end else if (!r_mph) begin
                        if (!r_mt[0]) begin
                            r_mt  <= r_mt >> 1;
                            r_mrs <= r_mrs + 5'd1;
                        end else begin
                            r_mph <= 1'b1;
                        end
                    end else if (r_mt[0]) begin
                        r_mt   <= r_mt >> 1;
                        r_mcnt <= r_mcnt + 6'd1;
                    end else if (r_mt != 32'd0) begin
                        // bits left above the run of ones: not contiguous
                        r_st <= ST_ERRO;
                    end else begin
                        r_rs[r_mch] <= m_rs_f;
                        r_ls[r_mch] <= m_ls_f;
                        r_mph       <= 1'b0;
                        if (r_mch == 2'd2) begin
                            r_active <= 1'b1;
                            r_st     <= ST_IDLE;
                        end else begin
                            r_mch  <= r_mch + 2'd1;
                            r_mt   <= r_cfg_mask[r_mch + 2'd1];
                            r_mrs  <= '0;
                            r_mcnt <= '0;
                        end
                    end
                end
                ST_ERRO: begin
                    if (out_free) r_st <= ST_IDLE;
                end
                ST_CALC: begin
                    r_col   <= n_col;
                    r_row   <= n_row;
                    r_bir   <= n_bir;
                    r_pos   <= n_pos;
                    r_pix   <= n_pix;
                    r_asm   <= n_asm;
                    r_phase <= n_phase;
                    r_cnt   <= n_cnt;
                    r_absl  <= n_absl;
                    r_fin   <= n_fin;
                    if (n_fin) r_active <= 1'b0;
                    for (int i = 0; i < 4; i++) r_cand[i] <= cand[i];
                    r_orow  <= r_up ? 13'(RW'(r_h) - RW'(1) - r_row) : 13'(r_row);
                    r_j     <= '0;
                    r_st    <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_j[2]) begin
                        r_st <= r_fin ? ST_FIN : ST_IDLE;
                    end else if (r_cand[r_j[1:0]].vld) begin
                        r_st <= ST_EMIT;
                    end else begin
                        r_j <= r_j + 3'd1;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_j  <= r_j + 3'd1;
                        r_st <= ST_SCAN;
                    end
                end
                ST_FIN: begin
                    if (out_free) r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/bmp_pixel_stream_decoder_unit_test.sv =====
// Self-checking bench for the BMP pixel stream decoder: random images checked against a predictor.
`default_nettype none
module bmp_pixel_stream_decoder_unit_test;

    localparam int MAXD = 8192;

    localparam logic [3:0] PH_COUNT  = 4'd0;
    localparam logic [3:0] PH_SECOND = 4'd1;
    localparam logic [3:0] PH_DX     = 4'd2;
    localparam logic [3:0] PH_DY     = 4'd3;
    localparam logic [3:0] PH_ABS    = 4'd4;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    bpsd_pkg::t_in_req   i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    bpsd_pkg::t_out_res  o_out_data;
    logic                i_cfg_we = 1'b0;
    logic [2:0]          i_cfg_index = bpsd_pkg::CFG_BPP;
    logic [31:0]         i_cfg_data = '0;

    bmp_pixel_stream_decoder_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // configuration registers as written
    logic [31:0] cfg_regs [8];
    // decoder state
    logic [23:0] palette [256];
    int unsigned col, row, byte_cnt, assembly, phase, rcount, abs_left;
    int unsigned rsh [3], lsh [3];
    bit          img_on;
    int unsigned a_bpp, a_comp, a_w, a_h, a_up, row_stride;

    bpsd_pkg::t_in_req  pending_reqs [$];
    bpsd_pkg::t_out_res expected_runs [$];
    bpsd_pkg::t_out_res batch [$];
    int       mismatches = 0;
    bit       hold_sender = 1'b0;
    bit       long_stall = 1'b0;
    int       accepted = 0;

    function automatic bpsd_pkg::t_out_res mk_res(logic [1:0] kind, int unsigned x,
                                                  int unsigned r, int unsigned n,
                                                  logic [23:0] c1, logic [23:0] c2);
        bpsd_pkg::t_out_res o;
        o = '0;
        o.result_kind = kind;
        o.pixel_x = x[12:0];
        o.pixel_row = r[12:0];
        o.run_length = n[7:0];
        {o.first_red, o.first_green, o.first_blue} = c1;
        {o.second_red, o.second_green, o.second_blue} = c2;
        return o;
    endfunction

    function automatic logic [23:0] pal_rd(int unsigned i);
        return (i < 256) ? palette[i] : 24'h0;
    endfunction

    task automatic finish_image();
        batch.push_back(mk_res(bpsd_pkg::RES_DONE, 0, 0, 0, 0, 0));
        img_on = 1'b0;
    endtask

    task automatic put_run(int unsigned x, int unsigned n, logic [23:0] c1, logic [23:0] c2);
        int unsigned len;
        int unsigned r;
        if (x >= a_w || n == 0) return;
        len = a_w - x;
        if (len > n) len = n;
        r = a_up ? (a_h - 1 - row) : row;
        batch.push_back(mk_res(bpsd_pkg::RES_RUN, x, r, len, c1, c2));
    endtask

    task automatic step_col(int unsigned n);
        col += n;
        if (col > MAXD) col = MAXD;
    endtask

    function automatic logic [23:0] to_rgb(int unsigned v);
        logic [7:0] ch [3];
        int unsigned f;
        for (int c = 0; c < 3; c++) begin
            if (lsh[c] >= 8) ch[c] = 8'd0;
            else begin
                f = (v >> rsh[c]) & ((1 << (8 - lsh[c])) - 1);
                ch[c] = 8'((f << lsh[c]) & 32'hff);
            end
        end
        return {ch[0], ch[1], ch[2]};
    endfunction

    function automatic bit mask_ok(int c, logic [31:0] m);
        logic [31:0] low, t;
        int unsigned rs, cnt;
        rs = 0;
        cnt = 0;
        if (m == 0) begin
            rsh[c] = 0; lsh[c] = 8;
            return 1'b1;
        end
        low = m & (~m + 32'd1);
        if (((m + low) & m) != 0) return 1'b0;
        t = m;
        while (t[0] == 1'b0) begin t = t >> 1; rs++; end
        while (t[0] == 1'b1) begin t = t >> 1; cnt++; end
        if (cnt > 8) begin rs += cnt - 8; cnt = 8; end
        rsh[c] = rs; lsh[c] = 8 - cnt;
        return 1'b1;
    endfunction

    task automatic start_image();
        bit ok;
        a_bpp = cfg_regs[bpsd_pkg::CFG_BPP] & 32'h3f;
        a_comp = cfg_regs[bpsd_pkg::CFG_COMP] & 32'h3;
        a_w = cfg_regs[bpsd_pkg::CFG_W] & 32'h3fff;
        a_h = cfg_regs[bpsd_pkg::CFG_H] & 32'h3fff;
        a_up = cfg_regs[bpsd_pkg::CFG_UP] & 32'h1;
        col = 0; row = 0; byte_cnt = 0; assembly = 0;
        phase = PH_COUNT; rcount = 0; abs_left = 0;
        for (int c = 0; c < 3; c++) begin rsh[c] = 0; lsh[c] = 0; end
        ok = a_bpp inside {1, 4, 8, 16, 24, 32};
        if (a_comp == bpsd_pkg::COMP_RLE8 && a_bpp != 8) ok = 0;
        if (a_comp == bpsd_pkg::COMP_RLE4 && a_bpp != 4) ok = 0;
        if (a_comp == bpsd_pkg::COMP_BF && a_bpp != 16 && a_bpp != 32) ok = 0;
        if (a_w < 1 || a_w > MAXD || a_h < 1 || a_h > MAXD) ok = 0;
        if (ok && a_comp == bpsd_pkg::COMP_BF) begin
            if (!mask_ok(0, cfg_regs[bpsd_pkg::CFG_RMASK])
                    || !mask_ok(1, cfg_regs[bpsd_pkg::CFG_GMASK])
                    || !mask_ok(2, cfg_regs[bpsd_pkg::CFG_BMASK]))
                ok = 0;
        end else if (ok && a_bpp == 16) begin
            rsh = '{10, 5, 0}; lsh = '{3, 3, 3};
        end else if (ok) begin
            rsh = '{16, 8, 0}; lsh = '{0, 0, 0};
        end
        if (!ok) begin
            img_on = 0;
            batch.push_back(mk_res(bpsd_pkg::RES_ERR, 0, 0, 0, 0, 0));
            return;
        end
        row_stride = (a_w * a_bpp + 31) / 32 * 4;
        img_on = 1;
    endtask

    task automatic plain_byte(int unsigned b);
        int unsigned k, bpb, pos;
        logic [23:0] c;
        k = byte_cnt;
        if (a_bpp == 1) begin
            for (int j = 0; j < 4; j++)
                put_run(8 * k + 2 * j, 2, pal_rd((b >> (7 - 2 * j)) & 1),
                        pal_rd((b >> (6 - 2 * j)) & 1));
        end else if (a_bpp == 4) begin
            put_run(2 * k, 2, pal_rd(b >> 4), pal_rd(b & 15));
        end else if (a_bpp == 8) begin
            put_run(k, 1, pal_rd(b), pal_rd(b));
        end else begin
            bpb = a_bpp / 8;
            pos = k % bpb;
            assembly = (pos == 0) ? b : (assembly | (b << (8 * pos)));
            if (pos == bpb - 1) begin
                c = to_rgb(assembly);
                put_run(k / bpb, 1, c, c);
            end
        end
        byte_cnt++;
        if (byte_cnt >= row_stride) begin
            byte_cnt = 0;
            row++;
            if (row >= a_h) finish_image();
        end
    endtask

    task automatic rle_byte(int unsigned b);
        bit r8;
        int unsigned n;
        logic [23:0] c1, c2;
        r8 = (a_comp == bpsd_pkg::COMP_RLE8);
        case (phase)
            PH_COUNT: begin
                rcount = b;
                phase = PH_SECOND;
            end
            PH_SECOND: begin
                phase = PH_COUNT;
                if (rcount != 0) begin
                    c1 = r8 ? pal_rd(b) : pal_rd(b >> 4);
                    c2 = r8 ? c1 : pal_rd(b & 15);
                    if (rcount == 1) c2 = c1;
                    put_run(col, rcount, c1, c2);
                    step_col(rcount);
                end else if (b == 0) begin
                    col = 0;
                    row++;
                    if (row >= a_h) finish_image();
                end else if (b == 1) begin
                    finish_image();
                end else if (b == 2) begin
                    phase = PH_DX;
                end else begin
                    rcount = b;
                    abs_left = r8 ? (b + 1) / 2 * 2 : (b + 3) / 4 * 2;
                    phase = PH_ABS;
                end
            end
            PH_DX: begin
                step_col(b);
                phase = PH_DY;
            end
            PH_DY: begin
                row += b;
                phase = PH_COUNT;
                if (row >= a_h) finish_image();
            end
            PH_ABS: begin
                if (abs_left > 0) abs_left--;
                if (rcount > 0) begin
                    n = (r8 || rcount < 2) ? 1 : 2;
                    c1 = r8 ? pal_rd(b) : pal_rd(b >> 4);
                    c2 = (n == 2) ? pal_rd(b & 15) : c1;
                    put_run(col, n, c1, c2);
                    step_col(n);
                    rcount -= n;
                end
                if (abs_left == 0) phase = PH_COUNT;
            end
            default: phase = PH_COUNT;
        endcase
    endtask

    task automatic predict_request(bpsd_pkg::t_in_req q);
        batch.delete();
        if (q.req_type == bpsd_pkg::REQ_PAL)
            palette[q.palette_index] = {q.palette_red, q.palette_green, q.palette_blue};
        else if (q.req_type == bpsd_pkg::REQ_START)
            start_image();
        else if (q.req_type == bpsd_pkg::REQ_DATA && img_on) begin
            if (a_comp == bpsd_pkg::COMP_RLE8 || a_comp == bpsd_pkg::COMP_RLE4)
                rle_byte(q.data_byte);
            else plain_byte(q.data_byte);
        end
        if (batch.size() > 0) batch[batch.size() - 1].last_of_item = 1'b1;
        foreach (batch[i]) expected_runs.push_back(batch[i]);
    endtask

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_request(i_in_data);
                accepted++;
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !hold_sender) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_reqs.pop_front();
                    send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int recv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_runs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", o_out_data);
                end else begin
                    bpsd_pkg::t_out_res e;
                    e = expected_runs.pop_front();
                    if (e !== o_out_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p actual %p", e, o_out_data);
                    end
                end
                recv_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
            end
            if (long_stall) i_out_ready <= 1'b0;
            else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else i_out_ready <= 1'b1;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        cfg_regs[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || expected_runs.size() > 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic bpsd_pkg::t_in_req mk_req(logic [1:0] kind, int unsigned b);
        bpsd_pkg::t_in_req q;
        q.req_type = kind;
        q.data_byte = b[7:0];
        q.palette_index = 8'($urandom);
        q.palette_red = 8'($urandom);
        q.palette_green = 8'($urandom);
        q.palette_blue = 8'($urandom);
        return q;
    endfunction

    task automatic add_palette(int n);
        for (int i = 0; i < n; i++)
            pending_reqs.push_back(mk_req(bpsd_pkg::REQ_PAL, $urandom));
    endtask

    task automatic setup(int unsigned bpp, int unsigned comp, int unsigned w, int unsigned h,
                         int unsigned up, logic [31:0] rm, logic [31:0] gm, logic [31:0] bm);
        drain();
        cfg_write(bpsd_pkg::CFG_BPP, bpp);
        cfg_write(bpsd_pkg::CFG_COMP, comp);
        cfg_write(bpsd_pkg::CFG_W, w);
        cfg_write(bpsd_pkg::CFG_H, h);
        cfg_write(bpsd_pkg::CFG_UP, up);
        cfg_write(bpsd_pkg::CFG_RMASK, rm);
        cfg_write(bpsd_pkg::CFG_GMASK, gm);
        cfg_write(bpsd_pkg::CFG_BMASK, bm);
    endtask

    // a well-formed RLE stream with random content
    task automatic add_rle_stream(bit r8, int ops);
        int unsigned n;
        for (int i = 0; i < ops; i++) begin
            case ($urandom_range(0, 9))
                0: begin
                    pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, 0));
                    pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, 0));
                end
                1: begin
                    pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, 0));
                    pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, 2));
                    pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, $urandom_range(0, 6)));
                    pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, $urandom_range(0, 1)));
                end
                2, 3: begin
                    n = $urandom_range(3, 12);
                    pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, 0));
                    pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, n));
                    n = r8 ? (n + 1) / 2 * 2 : (n + 3) / 4 * 2;
                    repeat (n) pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, $urandom));
                end
                4: pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, $urandom));
                default: begin
                    pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA,
                                                  ($urandom_range(0, 7) == 0) ?
                                                  $urandom_range(1, 255) : $urandom_range(1, 9)));
                    pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, $urandom));
                end
            endcase
        end
        pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, 0));
        pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, 1));
    endtask

    initial begin
        bpsd_pkg::t_in_req q;
        int unsigned bpp, w, h;
        int unsigned depths [6];
        depths = '{1, 4, 8, 16, 24, 32};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cfg_regs = '{24, 0, 1, 1, 1, 0, 0, 0};
        foreach (palette[i]) palette[i] = 24'h0;
        img_on = 0;

        // directed: extreme palette entries, reset config, bytes with no image, unused type
        q = mk_req(bpsd_pkg::REQ_PAL, 0); q.palette_index = 8'hff;
        q.palette_red = 8'hff; q.palette_green = 8'hff; q.palette_blue = 8'hff;
        pending_reqs.push_back(q);
        q = mk_req(bpsd_pkg::REQ_PAL, 8'hff); q.palette_index = 8'd0;
        q.palette_red = 8'd0; q.palette_green = 8'd0; q.palette_blue = 8'd0;
        pending_reqs.push_back(q);
        pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, 8'hff));
        pending_reqs.push_back(mk_req(2'd3, 8'h5a));
        pending_reqs.push_back(mk_req(bpsd_pkg::REQ_START, 0));
        repeat (4) pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, 8'hff));
        pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, 0));

        // configuration errors: bad depth, rle mismatch, non-contiguous mask, zero width
        setup(0, bpsd_pkg::COMP_RGB, 8192, 8192, 0, 0, 0, 0);
        pending_reqs.push_back(mk_req(bpsd_pkg::REQ_START, 0));
        pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, 1));
        setup(24, bpsd_pkg::COMP_RLE4, 3, 2, 0, 0, 0, 0);
        pending_reqs.push_back(mk_req(bpsd_pkg::REQ_START, 0));
        setup(16, bpsd_pkg::COMP_BF, 3, 2, 0, 32'h0000_0005, 32'h0, 32'h0);
        pending_reqs.push_back(mk_req(bpsd_pkg::REQ_START, 0));
        setup(32, bpsd_pkg::COMP_BF, 0, 2, 0, 0, 0, 0);
        pending_reqs.push_back(mk_req(bpsd_pkg::REQ_START, 0));
        // wide and zero masks, max width with few rows
        setup(32, bpsd_pkg::COMP_BF, 8192, 1, 1, 32'hffff_0000, 32'h0000_fff0, 32'h0);
        pending_reqs.push_back(mk_req(bpsd_pkg::REQ_START, 0));
        repeat (8) pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, $urandom));

        // random images
        for (int img = 0; img < 19 && accepted < 2000; img++) begin
            int unsigned comp;
            bpp = depths[$urandom_range(0, 5)];
            w = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 8192) : $urandom_range(1, 12);
            h = $urandom_range(1, 4);
            comp = bpsd_pkg::COMP_RGB;
            if (bpp == 8 && $urandom_range(0, 1)) comp = bpsd_pkg::COMP_RLE8;
            if (bpp == 4 && $urandom_range(0, 1)) comp = bpsd_pkg::COMP_RLE4;
            if ((bpp == 16 || bpp == 32) && $urandom_range(0, 1)) comp = bpsd_pkg::COMP_BF;
            if ($urandom_range(0, 15) == 0) comp = $urandom_range(0, 3);
            setup(bpp, comp, w, h, $urandom_range(0, 1),
                  (bpp == 16) ? 32'h0000_f800 : 32'h00ff_0000 << $urandom_range(0, 8),
                  (bpp == 16) ? 32'h0000_07e0 : 32'h0000_ff00,
                  ($urandom_range(0, 7) == 0) ? $urandom : 32'h0000_001f);
            add_palette($urandom_range(0, 6));
            pending_reqs.push_back(mk_req(bpsd_pkg::REQ_START, 0));
            if (comp == bpsd_pkg::COMP_RLE8 || comp == bpsd_pkg::COMP_RLE4)
                add_rle_stream(comp == bpsd_pkg::COMP_RLE8, $urandom_range(2, 8));
            else
                repeat ((w * bpp + 31) / 32 * 4 * h > 40 ? $urandom_range(5, 40)
                        : (w * bpp + 31) / 32 * 4 * h)
                    pending_reqs.push_back(mk_req(bpsd_pkg::REQ_DATA, $urandom));
            if (img == 6) begin
                // receiver stalls while the sender keeps offering
                fork
                    begin
                        long_stall = 1'b1;
                        repeat (300) @(posedge i_clk);
                        long_stall = 1'b0;
                    end
                join_none
            end
            if (img == 13) begin
                hold_sender = 1'b1;
                while (expected_runs.size() > 0 || i_in_valid) @(posedge i_clk);
                hold_sender = 1'b0;
            end
        end

        drain();
        if (mismatches == 0 && expected_runs.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
